// ===== rtl/sff_pkg.sv =====
package sff_pkg;

  // storage geometry (cell (x, y) sits at address {y, x})
  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int ADDR_W   = COL_W + ROW_W;
  localparam int DEPTH    = MAX_COLS * MAX_ROWS;

  // field widths
  localparam int OPC_W     = 3;
  localparam int POS_W     = 8;
  localparam int SZ_W      = 7;
  localparam int CELL_W    = 8;
  localparam int DIM_W     = 7;
  localparam int CFG_IDX_W = 2;

  // signed width for coordinate math: covers y + 2 * size_b and x - size_b
  localparam int CRD_W = 11;
  localparam logic signed [CRD_W-1:0] CRD_ZERO = '0;
  localparam logic signed [CRD_W-1:0] CRD_ONE  = CRD_W'(1);

  localparam logic [CELL_W-1:0] BLANK_CELL = CELL_W'(46);

  // command codes
  localparam logic [OPC_W-1:0] OP_CLEAR = 3'd0;
  localparam logic [OPC_W-1:0] OP_RECT  = 3'd1;
  localparam logic [OPC_W-1:0] OP_UP    = 3'd2;
  localparam logic [OPC_W-1:0] OP_DOWN  = 3'd3;
  localparam logic [OPC_W-1:0] OP_DIAM  = 3'd4;
  localparam logic [OPC_W-1:0] OP_READ  = 3'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_W = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_H = 2'd1;

  localparam logic [DIM_W-1:0] CANVAS_RESET = DIM_W'(64);
  localparam logic [DIM_W-1:0] COLS_CAP     = DIM_W'(MAX_COLS);
  localparam logic [DIM_W-1:0] ROWS_CAP     = DIM_W'(MAX_ROWS);

  // command queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  // classified command, as handed from front to back
  typedef struct packed {
    logic [OPC_W-1:0]        op;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [SZ_W-1:0]         a;
    logic [SZ_W-1:0]         b;
    logic [CELL_W-1:0]       brush;
    logic [DIM_W-1:0]        cols;
    logic                    fill;
    logic                    rd_hit;
    logic                    rsp_range;
    logic [ROW_W-1:0]        row_lo;
    logic [ROW_W-1:0]        row_hi;
    logic [COL_W-1:0]        rd_col;
    logic [ROW_W-1:0]        rd_row;
  } desc_t;

endpackage

// ===== rtl/sff_channels.sv =====
interface sff_cmd_if import sff_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OPC_W-1:0]        opcode;
  logic signed [POS_W-1:0] x_pos;
  logic signed [POS_W-1:0] y_pos;
  logic [SZ_W-1:0]         size_a;
  logic [SZ_W-1:0]         size_b;
  logic [CELL_W-1:0]       brush;

  modport source (output valid, opcode, x_pos, y_pos, size_a, size_b, brush, input ready);
  modport sink   (input valid, opcode, x_pos, y_pos, size_a, size_b, brush, output ready);
endinterface

interface sff_rsp_if import sff_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] pixel;
  logic              in_range;

  modport source (output valid, pixel, in_range, input ready);
  modport sink   (input valid, pixel, in_range, output ready);
endinterface

interface sff_cfg_if import sff_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/sff_front.sv =====
module sff_front import sff_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  sff_cmd_if.sink          cmd,
  input  logic [DIM_W-1:0] canvas_width,
  input  logic [DIM_W-1:0] canvas_height,
  input  logic             init_busy,
  input  logic             q_full,
  output logic             q_push,
  output desc_t            q_wdata
);

  logic                    held_v;
  logic [OPC_W-1:0]        h_op;
  logic signed [POS_W-1:0] h_x;
  logic signed [POS_W-1:0] h_y;
  logic [SZ_W-1:0]         h_a;
  logic [SZ_W-1:0]         h_b;
  logic [CELL_W-1:0]       h_brush;

  logic [DIM_W-1:0]        cols;
  logic [DIM_W-1:0]        rows;
  logic signed [CRD_W-1:0] xs, ys, bs, rows_s, cols_s;
  logic signed [CRD_W-1:0] lo, hi, lo_c, hi_c;
  logic                    is_draw;
  logic                    shape_zero;
  logic                    rows_ok;
  logic                    rd_hit;

  // one holding stage for the incoming word
  assign q_push    = held_v && !q_full;
  assign cmd.ready = !init_busy && (!held_v || !q_full);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_v <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      held_v <= 1'b1;
    end else if (q_push) begin
      held_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      h_op    <= cmd.opcode;
      h_x     <= cmd.x_pos;
      h_y     <= cmd.y_pos;
      h_a     <= cmd.size_a;
      h_b     <= cmd.size_b;
      h_brush <= cmd.brush;
    end
  end

  // active canvas, capped at storage size
  assign cols   = (canvas_width > COLS_CAP) ? COLS_CAP : canvas_width;
  assign rows   = (canvas_height > ROWS_CAP) ? ROWS_CAP : canvas_height;
  assign xs     = CRD_W'(h_x);
  assign ys     = CRD_W'(h_y);
  assign bs     = $signed(CRD_W'(h_b));
  assign rows_s = $signed(CRD_W'(rows));
  assign cols_s = $signed(CRD_W'(cols));

  // row band of each shape before clipping
  always_comb begin
    case (h_op)
      OP_CLEAR: begin
        lo = CRD_ZERO;
        hi = rows_s - CRD_ONE;
      end
      OP_RECT, OP_UP: begin
        lo = ys;
        hi = ys + bs - CRD_ONE;
      end
      OP_DOWN: begin
        lo = ys - bs + CRD_ONE;
        hi = ys;
      end
      OP_DIAM: begin
        lo = ys;
        hi = ys + bs + bs;
      end
      default: begin
        lo = CRD_ZERO;
        hi = -CRD_ONE;
      end
    endcase
  end

  assign lo_c    = (lo < CRD_ZERO) ? CRD_ZERO : lo;
  assign hi_c    = (hi > rows_s - CRD_ONE) ? rows_s - CRD_ONE : hi;
  assign rows_ok = (lo_c <= hi_c);

  // a diamond of zero distance still covers its apex
  assign is_draw    = h_op inside {[OP_CLEAR:OP_DIAM]};
  assign shape_zero = ((h_op == OP_RECT) && ((h_a == '0) || (h_b == '0))) ||
                      ((h_op inside {OP_UP, OP_DOWN}) && (h_b == '0));
  assign rd_hit     = (h_op == OP_READ) && (xs >= CRD_ZERO) && (xs < cols_s) &&
                      (ys >= CRD_ZERO) && (ys < rows_s);

  always_comb begin
    q_wdata           = '0;
    q_wdata.op        = h_op;
    q_wdata.x         = h_x;
    q_wdata.y         = h_y;
    q_wdata.a         = h_a;
    q_wdata.b         = h_b;
    q_wdata.brush     = (h_op == OP_CLEAR) ? BLANK_CELL : h_brush;
    q_wdata.cols      = cols;
    q_wdata.fill      = is_draw && !shape_zero && rows_ok;
    q_wdata.rd_hit    = rd_hit;
    q_wdata.rsp_range = is_draw || rd_hit;
    q_wdata.row_lo    = lo_c[ROW_W-1:0];
    q_wdata.row_hi    = hi_c[ROW_W-1:0];
    q_wdata.rd_col    = h_x[COL_W-1:0];
    q_wdata.rd_row    = h_y[ROW_W-1:0];
  end

endmodule

// ===== rtl/sff_queue.sv =====
module sff_queue import sff_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t wdata,
  output logic  full,
  input  logic  pop,
  output desc_t rdata,
  output logic  empty
);

  desc_t              slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_PTR_W:0]   count;

  assign full  = (count == (Q_PTR_W+1)'(Q_DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== rtl/sff_back.sv =====
module sff_back import sff_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_empty,
  input  desc_t   q_rdata,
  output logic    q_pop,
  output logic    init_busy,
  sff_rsp_if.source rsp
);

  localparam logic [2:0] ST_INIT = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_ROW  = 3'd2;
  localparam logic [2:0] ST_COL  = 3'd3;
  localparam logic [2:0] ST_READ = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]         state;
  desc_t              d;
  logic [ROW_W-1:0]   cur_row;
  logic [COL_W-1:0]   cur_col;
  logic [COL_W-1:0]   span_hi;
  logic [ADDR_W-1:0]  init_cnt;
  logic [CELL_W-1:0]  rd_data;
  logic [CELL_W-1:0]  mem [DEPTH];

  logic                    we;
  logic [ADDR_W-1:0]       waddr;
  logic [CELL_W-1:0]       wdata;
  logic                    rsp_load;
  logic signed [CRD_W-1:0] xs, ys, as, bs, row_s, cols_s, dy, half;
  logic signed [CRD_W-1:0] lo, hi, lo_c, hi_c;
  logic                    span_ok;

  assign init_busy = (state == ST_INIT);
  assign q_pop     = (state == ST_IDLE) && !q_empty;
  assign rsp_load  = (state == ST_DONE) && (!rsp.valid || rsp.ready);

  // span of the current row
  assign xs     = CRD_W'(d.x);
  assign ys     = CRD_W'(d.y);
  assign as     = $signed(CRD_W'(d.a));
  assign bs     = $signed(CRD_W'(d.b));
  assign row_s  = $signed(CRD_W'(cur_row));
  assign cols_s = $signed(CRD_W'(d.cols));
  assign dy     = (d.op == OP_DOWN) ? ys - row_s : row_s - ys;
  assign half   = (dy <= bs) ? dy : bs + bs - dy;

  always_comb begin
    case (d.op)
      OP_CLEAR: begin
        lo = CRD_ZERO;
        hi = cols_s - CRD_ONE;
      end
      OP_RECT: begin
        lo = xs;
        hi = xs + as - CRD_ONE;
      end
      OP_UP, OP_DOWN: begin
        lo = xs - dy;
        hi = xs + dy;
      end
      OP_DIAM: begin
        lo = xs - half;
        hi = xs + half;
      end
      default: begin
        lo = CRD_ZERO;
        hi = -CRD_ONE;
      end
    endcase
  end

  assign lo_c    = (lo < CRD_ZERO) ? CRD_ZERO : lo;
  assign hi_c    = (hi > cols_s - CRD_ONE) ? cols_s - CRD_ONE : hi;
  assign span_ok = (lo_c <= hi_c);

  // sequencer: clearing pass, row setup, cell writes, read, result
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      init_cnt <= '0;
    end else begin
      case (state)
        ST_INIT: begin
          init_cnt <= init_cnt + 1'b1;
          if (init_cnt == ADDR_W'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (!q_empty) begin
            if (q_rdata.fill) begin
              state <= ST_ROW;
            end else if (q_rdata.rd_hit) begin
              state <= ST_READ;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_ROW: begin
          if (span_ok) begin
            state <= ST_COL;
          end else if (cur_row == d.row_hi) begin
            state <= ST_DONE;
          end
        end
        ST_COL: begin
          if (cur_col == span_hi) begin
            state <= (cur_row == d.row_hi) ? ST_DONE : ST_ROW;
          end
        end
        ST_READ: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (rsp_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      d       <= q_rdata;
      cur_row <= q_rdata.row_lo;
    end
    if (state == ST_ROW) begin
      cur_col <= lo_c[COL_W-1:0];
      span_hi <= hi_c[COL_W-1:0];
      if (!span_ok && (cur_row != d.row_hi)) begin
        cur_row <= cur_row + 1'b1;
      end
    end
    if (state == ST_COL) begin
      if (cur_col != span_hi) begin
        cur_col <= cur_col + 1'b1;
      end else if (cur_row != d.row_hi) begin
        cur_row <= cur_row + 1'b1;
      end
    end
  end

  // frame store, one write port and one registered read port
  assign we    = (state == ST_INIT) || (state == ST_COL);
  assign waddr = (state == ST_INIT) ? init_cnt : {cur_row, cur_col};
  assign wdata = (state == ST_INIT) ? BLANK_CELL : d.brush;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (state == ST_READ) begin
      rd_data <= mem[{d.rd_row, d.rd_col}];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (rsp_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.pixel    <= d.rd_hit ? rd_data : '0;
      rsp.in_range <= d.rsp_range;
    end
  end

  a_col_in_span: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COL) |-> (cur_col <= span_hi))
    else $error("column walk passed the span end");

  a_row_in_band: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COL) |-> ((cur_row >= d.row_lo) && (cur_row <= d.row_hi)))
    else $error("row walk left the clipped band");

  a_pop_idle_only: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> ((state == ST_IDLE) && !init_busy))
    else $error("queue popped while busy");

  a_draw_pixel_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_load && !d.rd_hit) |=> (rsp.pixel == '0))
    else $error("nonzero pixel on a result that is no read hit");

endmodule

// ===== rtl/shape_fill_framebuffer.sv =====
// Character framebuffer with command-driven shape fill.
// Channels: cmd takes one command word (opcode, x_pos, y_pos, size_a, size_b,
// brush); rsp returns exactly one word (pixel, in_range) per command, in order;
// cfg writes canvas_width (index 0) or canvas_height (index 1), ready always
// high. Write cfg only while no command is in flight.
// Flow: a command word is held in the holding stage, queued, then run by the raster
// sequencer, which takes the command from the queue, runs one setup step per
// clipped row and one write per written cell (one frame-store write port), then
// loads the result. A read hit fetches its pixel through the registered read
// port; other commands that write no cell go straight to the result. The holding
// stage and the result register sit on either side of the queue and sequencer.
// Commands follow one another at the sequencer's pace.
// Up to four classified commands queue ahead of the sequencer.
// Reset: a clearing pass writes '.' into all 4096 cells with cmd.ready low;
// the canvas registers return to 64 by 64.
// Stall: when rsp is not taken the sequencer waits at its finished result and
// the queue fills; cmd.ready drops once the queue and holding stage are full.
module shape_fill_framebuffer import sff_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  sff_cmd_if.sink   cmd,
  sff_rsp_if.source rsp,
  sff_cfg_if.sink   cfg
);

  logic [DIM_W-1:0] canvas_width;
  logic [DIM_W-1:0] canvas_height;
  logic             init_busy;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  desc_t            q_wdata;
  desc_t            q_rdata;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= CANVAS_RESET;
      canvas_height <= CANVAS_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_CANVAS_W: canvas_width  <= cfg.data;
        REG_CANVAS_H: canvas_height <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  sff_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .canvas_width  (canvas_width),
    .canvas_height (canvas_height),
    .init_busy     (init_busy),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_wdata       (q_wdata)
  );

  sff_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  sff_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .rsp       (rsp)
  );

endmodule

// ===== bench/tb_shape_fill_framebuffer.sv =====
`timescale 1ns / 1ps

module tb_shape_fill_framebuffer;
  import sff_pkg::*;

  // opcodes and register indexes the block must ignore
  localparam logic [OPC_W-1:0]     OP_SPARE6 = 3'd6;
  localparam logic [OPC_W-1:0]     OP_SPARE7 = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam int RAND_PER_PHASE = 50;
  localparam int N_PHASES       = 8;
  localparam int MAX_NOTES      = 10;

  typedef struct {
    logic [OPC_W-1:0]        op;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [SZ_W-1:0]         a;
    logic [SZ_W-1:0]         b;
    logic [CELL_W-1:0]       brush;
  } draw_cmd_t;

  typedef struct {
    logic [CELL_W-1:0] pixel;
    logic              in_range;
  } cell_reply_t;

  logic clk;
  logic rst;

  sff_cmd_if cmd_ch ();
  sff_rsp_if rsp_ch ();
  sff_cfg_if cfg_ch ();

  shape_fill_framebuffer dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // shadow copy of the frame and canvas registers
  logic [CELL_W-1:0] shadow_frame [DEPTH];
  logic [DIM_W-1:0]  canvas_w;
  logic [DIM_W-1:0]  canvas_h;

  draw_cmd_t   queued_cmds [$];
  cell_reply_t awaited_replies [$];
  draw_cmd_t   cur_cmd;

  bit cmd_held;
  bit send_calm;
  bit recv_calm;
  int send_gap;
  int recv_gap;

  int n_sent;
  int n_replies;
  int n_read_hits;
  int n_cfg_writes;
  int n_errors;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // columns or rows actually in use: register value capped by storage
  function automatic int active_span(logic [DIM_W-1:0] dim, logic [DIM_W-1:0] cap);
    return (dim < cap) ? int'(dim) : int'(cap);
  endfunction

  function automatic bit shape_hit(logic [OPC_W-1:0] op, int cx, int cy,
                                   int x, int y, int a, int b);
    int dx;
    int dy;
    int half;
    dx = cx - x;
    if (dx < 0) half = -dx;
    else half = dx;
    // half now holds |dx|
    case (op)
      OP_RECT: begin
        dy = cy - y;
        return dx >= 0 && dx < a && dy >= 0 && dy < b;
      end
      OP_UP: begin
        dy = cy - y;
        return dy >= 0 && dy < b && half <= dy;
      end
      OP_DOWN: begin
        dy = y - cy;
        return dy >= 0 && dy < b && half <= dy;
      end
      OP_DIAM: begin
        dy = cy - y;
        if (dy < 0 || dy > 2 * b) return 1'b0;
        if (dy <= b) return half <= dy;
        return half <= 2 * b - dy;
      end
      default: return 1'b0;
    endcase
  endfunction

  // update the shadow frame for one command and return the reply it earns
  function automatic cell_reply_t paint_and_reply(draw_cmd_t c);
    cell_reply_t r;
    int cols;
    int rows;
    int x;
    int y;
    int cx;
    int cy;
    cols = active_span(canvas_w, COLS_CAP);
    rows = active_span(canvas_h, ROWS_CAP);
    x = c.x;
    y = c.y;
    r.pixel = '0;
    r.in_range = 1'b0;
    if (c.op == OP_CLEAR) begin
      for (cy = 0; cy < rows; cy++)
        for (cx = 0; cx < cols; cx++)
          shadow_frame[cy * MAX_COLS + cx] = BLANK_CELL;
      r.in_range = 1'b1;
    end else if (c.op >= OP_RECT && c.op <= OP_DIAM) begin
      for (cy = 0; cy < rows; cy++)
        for (cx = 0; cx < cols; cx++)
          if (shape_hit(c.op, cx, cy, x, y, int'(c.a), int'(c.b)))
            shadow_frame[cy * MAX_COLS + cx] = c.brush;
      r.in_range = 1'b1;
    end else if (c.op == OP_READ) begin
      if (x >= 0 && x < cols && y >= 0 && y < rows) begin
        r.pixel = shadow_frame[y * MAX_COLS + x];
        r.in_range = 1'b1;
        n_read_hits++;
      end
    end
    return r;
  endfunction

  function automatic void push_cmd(logic [OPC_W-1:0] op, int x, int y, int a, int b,
                                   int brush);
    draw_cmd_t c;
    c.op = op;
    c.x = POS_W'(x);
    c.y = POS_W'(y);
    c.a = SZ_W'(a);
    c.b = SZ_W'(b);
    c.brush = CELL_W'(brush);
    queued_cmds.push_back(c);
  endfunction

  // mostly near the canvas, now and then anywhere in the signed range
  function automatic logic signed [POS_W-1:0] pick_coord(int span);
    if ($urandom_range(0, 9) == 0) return POS_W'($urandom_range(0, 255));
    return POS_W'($urandom_range(0, span + 15) - 8);
  endfunction

  // small shapes keep the raster short; a few go to full size
  function automatic logic [SZ_W-1:0] pick_size();
    if ($urandom_range(0, 11) == 0) return SZ_W'($urandom_range(0, 127));
    return SZ_W'($urandom_range(0, 12));
  endfunction

  function automatic draw_cmd_t random_cmd();
    draw_cmd_t c;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 2) c.op = OP_CLEAR;
    else if (pick < 22) c.op = OP_RECT;
    else if (pick < 37) c.op = OP_UP;
    else if (pick < 52) c.op = OP_DOWN;
    else if (pick < 66) c.op = OP_DIAM;
    else if (pick < 97) c.op = OP_READ;
    else if (pick[0]) c.op = OP_SPARE6;
    else c.op = OP_SPARE7;
    c.x = pick_coord(active_span(canvas_w, COLS_CAP));
    c.y = pick_coord(active_span(canvas_h, ROWS_CAP));
    c.a = pick_size();
    c.b = pick_size();
    c.brush = CELL_W'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic void note_failure(string msg);
    n_errors++;
    if (n_errors <= MAX_NOTES) $display("mismatch: %s", msg);
  endfunction

  task automatic check_reply(logic [CELL_W-1:0] pixel, logic in_range);
    cell_reply_t want;
    if (awaited_replies.size() == 0) begin
      note_failure($sformatf("reply with none outstanding: pixel=%02h in_range=%0b",
                             pixel, in_range));
    end else begin
      want = awaited_replies.pop_front();
      n_replies++;
      if (pixel !== want.pixel)
        note_failure($sformatf("reply %0d pixel: expected %02h, got %02h",
                               n_replies, want.pixel, pixel));
      if (in_range !== want.in_range)
        note_failure($sformatf("reply %0d in_range: expected %0b, got %0b",
                               n_replies, want.in_range, in_range));
    end
  endtask

  // canvas register write; only called with nothing in flight
  task automatic write_canvas_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_CANVAS_W) canvas_w = val;
    else if (idx == REG_CANVAS_H) canvas_h = val;
    n_cfg_writes++;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (queued_cmds.size() != 0 || cmd_held || awaited_replies.size() != 0);
  endtask

  // command driver: one word per handshake, random gap before each word
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      cmd_held = 1'b0;
      send_gap = 0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        awaited_replies.push_back(paint_and_reply(cur_cmd));
        n_sent++;
        cmd_held = 1'b0;
        if ($urandom_range(0, 19) == 0) send_calm = !send_calm;
        send_gap = send_calm ? 0 : $urandom_range(0, 11);
      end
      if (!cmd_held) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (queued_cmds.size() != 0) begin
          cur_cmd = queued_cmds.pop_front();
          cmd_ch.opcode <= cur_cmd.op;
          cmd_ch.x_pos  <= cur_cmd.x;
          cmd_ch.y_pos  <= cur_cmd.y;
          cmd_ch.size_a <= cur_cmd.a;
          cmd_ch.size_b <= cur_cmd.b;
          cmd_ch.brush  <= cur_cmd.brush;
          cmd_held = 1'b1;
        end
      end
      cmd_ch.valid <= cmd_held;
    end
  end

  // reply monitor with random back-pressure
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        check_reply(rsp_ch.pixel, rsp_ch.in_range);
        if ($urandom_range(0, 19) == 0) recv_calm = !recv_calm;
        recv_gap = recv_calm ? 0 : $urandom_range(0, 11);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // stimulus: directed commands, then random phases over several canvas sizes
  initial begin : stimulus
    int phase_w [N_PHASES];
    int phase_h [N_PHASES];
    int ph;
    int k;

    phase_w = '{1, 127, 0, 37, 64, 5, 20, 64};
    phase_h = '{1, 127, 20, 13, 1, 64, 0, 64};

    foreach (shadow_frame[i]) shadow_frame[i] = BLANK_CELL;
    canvas_w = CANVAS_RESET;
    canvas_h = CANVAS_RESET;

    rst = 1'b1;
    cmd_ch.valid  = 1'b0;
    cmd_ch.opcode = OP_CLEAR;
    cmd_ch.x_pos  = '0;
    cmd_ch.y_pos  = '0;
    cmd_ch.size_a = '0;
    cmd_ch.size_b = '0;
    cmd_ch.brush  = '0;
    rsp_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = REG_CANVAS_W;
    cfg_ch.data   = CANVAS_RESET;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: corners, misses, zero sizes, each shape, clipping, spare codes
    push_cmd(OP_READ, 0, 0, 0, 0, 0);
    push_cmd(OP_READ, 63, 63, 0, 0, 0);
    push_cmd(OP_READ, 64, 0, 0, 0, 0);
    push_cmd(OP_READ, -1, 5, 0, 0, 0);
    push_cmd(OP_READ, 127, -128, 0, 0, 0);
    push_cmd(OP_RECT, 0, 0, 0, 5, 8'h5A);
    push_cmd(OP_RECT, 3, 3, 5, 0, 8'h5A);
    push_cmd(OP_RECT, -3, -2, 10, 6, 8'hFF);
    push_cmd(OP_READ, 0, 0, 0, 0, 0);
    push_cmd(OP_UP, 10, 5, 0, 8, 8'h41);
    push_cmd(OP_READ, 3, 12, 0, 0, 0);
    push_cmd(OP_READ, 2, 12, 0, 0, 0);
    push_cmd(OP_DOWN, 30, 40, 0, 10, 8'h00);
    push_cmd(OP_READ, 21, 31, 0, 0, 0);
    push_cmd(OP_DIAM, 50, 20, 0, 6, 8'h80);
    push_cmd(OP_READ, 50, 32, 0, 0, 0);
    push_cmd(OP_DIAM, 5, 60, 0, 0, 8'h7F);
    push_cmd(OP_DIAM, -128, -128, 0, 127, 8'h55);
    push_cmd(OP_RECT, 0, 0, 127, 127, 8'h01);
    push_cmd(OP_UP, 127, 127, 127, 127, 8'hAA);
    push_cmd(OP_SPARE6, 1, 1, 1, 1, 8'h33);
    push_cmd(OP_SPARE7, 2, 2, 2, 2, 8'hCC);
    push_cmd(OP_READ, 63, 0, 0, 0, 0);
    push_cmd(OP_CLEAR, 0, 0, 0, 0, 0);
    push_cmd(OP_READ, 63, 0, 0, 0, 0);
    wait_drained();

    // random phases; each phase waits until all replies are back
    for (ph = 0; ph < N_PHASES; ph++) begin
      repeat (4) @(posedge clk);
      write_canvas_reg(REG_CANVAS_W, DIM_W'(phase_w[ph]));
      write_canvas_reg(REG_CANVAS_H, DIM_W'(phase_h[ph]));
      if (ph == 3) write_canvas_reg(REG_SPARE, DIM_W'(8'h55));
      for (k = 0; k < RAND_PER_PHASE; k++) queued_cmds.push_back(random_cmd());
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (awaited_replies.size() != 0)
      note_failure($sformatf("%0d replies never arrived", awaited_replies.size()));

    $display("covered %0d commands (%0d in-canvas reads) over %0d register writes",
             n_sent, n_read_hits, n_cfg_writes);
    $display("checked %0d replies, %0d failures", n_replies, n_errors);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #200_000_000;
    $display("timeout with %0d replies outstanding", awaited_replies.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
